>>> rtl/lpht_pkg.sv
package lpht_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int KEY_W       = 8;
  localparam int INDEX_W     = 4;
  localparam int KEY_VALUES  = 1 << KEY_W;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } lpht_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the new transaction
    logic probe;   // step the probe sequence
    logic finish;  // register the result
  } lpht_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic miss;
  } lpht_sts_t;

  typedef logic [SLOT_W-1:0] home_lut_t [KEY_VALUES];

  // Home slot of every key, worked out at elaboration
  function automatic home_lut_t build_home_lut();
    home_lut_t lut;
    for (int i = 0; i < KEY_VALUES; i++) begin
      lut[i] = SLOT_W'(i % TABLE_SLOTS);
    end
    return lut;
  endfunction

  localparam home_lut_t HOME_LUT = build_home_lut();

  // Keep the low bits of a slot number for the result field
  function automatic logic [INDEX_W-1:0] to_index(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W+INDEX_W-1:0] wide;
    wide = {{INDEX_W{1'b0}}, slot};
    return wide[INDEX_W-1:0];
  endfunction

endpackage

>>> rtl/linear_probe_hash_table_unit.sv
// Channel    Direction  Handshake                      Payload
// command    in         start high while busy low      operation_i, key_i
// result     out        done_o high for one cycle      success_o, slot_index_o
//
// An insert probes up to TABLE_SLOTS slots, one slot a cycle.
// A search probes the same way but decides on the key from the registered key RAM read.
// The result strobe is registered from the deciding probe; start may come while it is shown.
// Reset clears every used bit at once; stored keys are left as they are.
// The receiver cannot stall: each result is shown for exactly one cycle.
module linear_probe_hash_table_unit
  import lpht_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               operation_i,
  input  logic [KEY_W-1:0]   key_i,
  output logic               done_o,
  output logic               success_o,
  output logic [INDEX_W-1:0] slot_index_o
);

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  lpht_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .sts_o        (sts),
    .done_o       (done_o),
    .success_o    (success_o),
    .slot_index_o (slot_index_o)
  );

  // A probe run never ends as both hit and miss
  a_hit_miss_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts.hit && sts.miss))
    else $error("hit and miss together");

  // Every result closes a probe run
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a probe run");

  // An accepted transaction starts probing
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transaction accepted but not probing");

  // A failed result reports slot zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !success_o) |-> (slot_index_o == '0))
    else $error("failure with non-zero slot");

endmodule

>>> rtl/lpht_ram.sv
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lpht_ctrl.sv
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  lpht_sts_t sts_i,
  output lpht_cmd_t cmd_o,
  output logic      busy
);

  lpht_state_e state_q, state_d;

  // Hold or advance the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (sts_i.hit || sts_i.miss) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    busy  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_PROBE: begin
        busy         = 1'b1;
        cmd_o.probe  = 1'b1;
        cmd_o.finish = sts_i.hit || sts_i.miss;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> rtl/lpht_dpath.sv
module lpht_dpath
  import lpht_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpht_cmd_t          cmd_i,
  input  logic               operation_i,
  input  logic [KEY_W-1:0]   key_i,
  output lpht_sts_t          sts_o,
  output logic               done_o,
  output logic               success_o,
  output logic [INDEX_W-1:0] slot_index_o
);

  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [SLOT_W-1:0]  addr_q, addr_d;
  logic [CNT_W-1:0]   cnt_q;
  logic               chk_vld_q;
  logic               chk_last_q;
  logic               chk_used_q;
  logic [SLOT_W-1:0]  chk_addr_q;
  logic [TABLE_SLOTS-1:0] used_q;
  logic               done_q;
  logic               success_q;
  logic [INDEX_W-1:0] slot_q;

  logic               issue;
  logic               last_probe;
  logic               key_match;
  logic               ins_hit;
  logic               ins_miss;
  logic               srch_hit;
  logic               srch_miss;
  logic               ram_we;
  logic [KEY_W-1:0]   rdata;

  // Probe sequence: next slot with wrap
  assign addr_d     = (addr_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : addr_q + 1'b1;
  assign issue      = cmd_i.probe && (cnt_q < CNT_W'(TABLE_SLOTS));
  assign last_probe = (cnt_q == CNT_W'(TABLE_SLOTS - 1));

  // Insert decides on the slot's used bit in the issue cycle
  assign ins_hit  = cmd_i.probe && (op_q == OP_INSERT) && issue && !used_q[addr_q];
  assign ins_miss = cmd_i.probe && (op_q == OP_INSERT) && issue && used_q[addr_q]
                    && last_probe;

  // Search decides in the cycle after the issue, on the stored key
  assign key_match = (rdata == key_q);
  assign srch_hit  = cmd_i.probe && (op_q == OP_SEARCH) && chk_vld_q && chk_used_q
                     && key_match;
  assign srch_miss = cmd_i.probe && (op_q == OP_SEARCH) && chk_vld_q && chk_last_q
                     && !(chk_used_q && key_match);

  assign sts_o.hit  = ins_hit || srch_hit;
  assign sts_o.miss = ins_miss || srch_miss;

  assign ram_we = ins_hit;

  lpht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (key_q),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // Capture the transaction and step the probe
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      key_q  <= key_i;
      addr_q <= HOME_LUT[key_i];
      cnt_q  <= '0;
    end else if (issue) begin
      addr_q <= addr_d;
      cnt_q  <= cnt_q + 1'b1;
    end
    chk_addr_q <= addr_q;
    chk_used_q <= used_q[addr_q];
    chk_last_q <= last_probe;
  end

  // Track the read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_vld_q <= 1'b0;
    end else begin
      chk_vld_q <= issue && (op_q == OP_SEARCH);
    end
  end

  // Mark slots taken by inserts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (ins_hit) begin
      used_q[addr_q] <= 1'b1;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      success_q <= sts_o.hit;
      if (ins_hit) begin
        slot_q <= to_index(addr_q);
      end else if (srch_hit) begin
        slot_q <= to_index(chk_addr_q);
      end else begin
        slot_q <= '0;
      end
    end
  end

  assign done_o       = done_q;
  assign success_o    = success_q;
  assign slot_index_o = slot_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import lpht_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_TAIL   = 200;
  localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } table_cmd_t;

  typedef struct packed {
    logic               success;
    logic [INDEX_W-1:0] slot_index;
  } table_res_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               operation_i = OP_INSERT;
  logic [KEY_W-1:0]   key_i       = '0;
  logic               busy;
  logic               done_o;
  logic               success_o;
  logic [INDEX_W-1:0] slot_index_o;

  table_cmd_t       pending_cmds[$];
  table_res_t       expected_results[$];
  logic             model_used [TABLE_SLOTS];
  logic [KEY_W-1:0] model_key  [TABLE_SLOTS];

  int gap_left       = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int items_total    = 0;
  int items_accepted = 0;
  int results_popped = 0;

  initial begin
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      model_used[s] = 1'b0;
      model_key[s]  = '0;
    end
  end

  always #5 clk_i = ~clk_i;

  linear_probe_hash_table_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .done_o       (done_o),
    .success_o    (success_o),
    .slot_index_o (slot_index_o)
  );

  // Walk the probe sequence from the home slot; an insert claims the first free slot,
  // a search reports the first occupied slot holding the key
  function automatic table_res_t probe_table(input table_cmd_t cmd);
    table_res_t res;
    int         slot;
    res = '0;
    for (int step = 0; step < TABLE_SLOTS; step++) begin
      slot = (int'(cmd.key) + step) % TABLE_SLOTS;
      if (cmd.op == OP_INSERT) begin
        if (!model_used[slot]) begin
          model_used[slot] = 1'b1;
          model_key[slot]  = cmd.key;
          res.success      = 1'b1;
          res.slot_index   = INDEX_W'(slot);
          return res;
        end
      end else if (model_used[slot] && model_key[slot] == cmd.key) begin
        res.success    = 1'b1;
        res.slot_index = INDEX_W'(slot);
        return res;
      end
    end
    return res;
  endfunction

  task automatic add_cmd(input logic op, input logic [KEY_W-1:0] key);
    pending_cmds.push_back(table_cmd_t'{op: op, key: key});
    items_total++;
  endtask

  // Driver: predict on acceptance, then hold, idle or present the next transaction
  always @(posedge clk_i) begin : drive_proc
    table_cmd_t cur_cmd;
    table_cmd_t next_cmd;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cur_cmd.op  = operation_i;
        cur_cmd.key = key_i;
        expected_results.push_back(probe_table(cur_cmd));
        items_accepted++;
        if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 17);
        end
      end
      if (start && busy) begin
        // hold the transaction until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_cmd    = pending_cmds.pop_front();
        start       <= 1'b1;
        operation_i <= next_cmd.op;
        key_i       <= next_cmd.key;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction
  always @(posedge clk_i) begin : check_proc
    table_res_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected result: success %0b slot_index %0d", success_o, slot_index_o);
        end
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_popped++;
        if (want.success !== success_o || want.slot_index !== slot_index_o) begin
          if (mismatches < MAX_REPORTS) begin
            $display("result mismatch: expected success %0b slot_index %0d, got %0b %0d",
                     want.success, want.slot_index, success_o, slot_index_o);
          end
          mismatches++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[linear_probe_hash_table_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus_proc
    logic [KEY_W-1:0] stored_keys[$];
    logic             op;
    logic [KEY_W-1:0] key;
    int               pick;

    // Directed: empty-table miss, wrap from the last slot, duplicates, clustering
    add_cmd(OP_SEARCH, 8'h00);
    add_cmd(OP_INSERT, 8'hFF);
    add_cmd(OP_INSERT, 8'h0F);
    add_cmd(OP_INSERT, 8'h1F);
    add_cmd(OP_INSERT, 8'hFF);
    add_cmd(OP_SEARCH, 8'hFF);
    add_cmd(OP_SEARCH, 8'h0F);
    add_cmd(OP_SEARCH, 8'h1F);
    add_cmd(OP_SEARCH, 8'h2F);
    add_cmd(OP_INSERT, 8'h00);
    add_cmd(OP_SEARCH, 8'h00);
    add_cmd(OP_INSERT, 8'h80);
    add_cmd(OP_SEARCH, 8'h80);
    add_cmd(OP_SEARCH, 8'h7F);
    add_cmd(OP_SEARCH, 8'hAA);
    add_cmd(OP_INSERT, 8'h55);
    add_cmd(OP_SEARCH, 8'h55);
    stored_keys = '{8'hFF, 8'h0F, 8'h1F, 8'hFF, 8'h00, 8'h80, 8'h55};

    // Random: sparse inserts fill the table gradually, mixed with searches; later inserts meet a full table
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      op   = ($urandom_range(0, 7) == 0) ? OP_INSERT : OP_SEARCH;
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        key = KEY_W'($urandom_range(0, KEY_VALUES - 1));
      end else if (pick == 1 || op == OP_INSERT) begin
        key = {4'($urandom_range(0, 15)), 4'($urandom_range(12, 15))};
      end else begin
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end
      if (op == OP_INSERT && stored_keys.size() < TABLE_SLOTS) begin
        stored_keys.push_back(key);
      end
      add_cmd(op, key);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (items_accepted == items_total);
    wait (results_popped == items_total);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[linear_probe_hash_table_unit] OK");
    end else begin
      $display("[linear_probe_hash_table_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> linear_probe_hash_table_unit.f
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_ctrl.sv
rtl/lpht_dpath.sv
rtl/linear_probe_hash_table_unit.sv
tb/tb.sv
